// ----- hdl/abp_pkg.sv -----
// Shared constants, codes and blend arithmetic for the alpha blend paste block.
`default_nettype none

package abp_pkg;

   // Framebuffer geometry
   localparam int MAX_WIDTH   = 64;
   localparam int MAX_HEIGHT  = 64;
   localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int STORE_AW    = $clog2(STORE_DEPTH);
   localparam int COL_W       = $clog2(MAX_WIDTH);
   localparam int ROW_W       = $clog2(MAX_HEIGHT);

   // Field widths
   localparam int ADDR_W = 12;
   localparam int CHAN_W = 8;
   localparam int PIX_W  = 4 * CHAN_W;
   localparam int DIM_W  = 7;
   localparam int OFS_W  = 8;
   localparam int CSR_IW = 3;

   localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hFF;

   typedef enum logic [1:0] {
      OP_WRITE  = 2'd0,
      OP_READ   = 2'd1,
      OP_PASTE  = 2'd2,
      OP_UNUSED = 2'd3
   } op_type;

   typedef enum logic [CSR_IW-1:0] {
      REG_DEST_WIDTH  = 3'd0,
      REG_DEST_HEIGHT = 3'd1,
      REG_SUB_WIDTH   = 3'd2,
      REG_SUB_HEIGHT  = 3'd3,
      REG_PASTE_X     = 3'd4,
      REG_PASTE_Y     = 3'd5
   } reg_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_MIX,
      ST_PUSH
   } state_type;

   // Source-over colour: (a*s + (256-a)*d) >> 8
   function automatic logic [CHAN_W-1:0] mix_chan(input logic [CHAN_W-1:0] s,
                                                  input logic [CHAN_W-1:0] d,
                                                  input logic [CHAN_W-1:0] a);
      logic [CHAN_W:0]     inv;
      logic [2*CHAN_W:0]   sum;
      inv = 9'd256 - {1'b0, a};
      sum = ((2*CHAN_W+1)'(a) * (2*CHAN_W+1)'(s))
          + ((2*CHAN_W+1)'(inv) * (2*CHAN_W+1)'(d));
      return sum[2*CHAN_W-1:CHAN_W];
   endfunction

   // Alpha: 255 - (((255-da)*(255-sa)) >> 8)
   function automatic logic [CHAN_W-1:0] mix_alpha(input logic [CHAN_W-1:0] da,
                                                   input logic [CHAN_W-1:0] sa);
      logic [2*CHAN_W-1:0] prod;
      prod = (2*CHAN_W)'(CHAN_MAX - da) * (2*CHAN_W)'(CHAN_MAX - sa);
      return CHAN_MAX - prod[2*CHAN_W-1:CHAN_W];
   endfunction

endpackage

`default_nettype wire

// ----- hdl/abp_if.sv -----
// Channel interfaces for the alpha blend paste block: request, response, register write.
`default_nettype none

interface abp_req_if;
   import abp_pkg::*;
   logic              valid;
   logic              ready;
   logic [1:0]        operation;
   logic [ADDR_W-1:0] address;
   logic [CHAN_W-1:0] pixel_red;
   logic [CHAN_W-1:0] pixel_green;
   logic [CHAN_W-1:0] pixel_blue;
   logic [CHAN_W-1:0] pixel_alpha;

   modport source (output valid, operation, address, pixel_red, pixel_green,
                   pixel_blue, pixel_alpha, input ready);
   modport sink   (input valid, operation, address, pixel_red, pixel_green,
                   pixel_blue, pixel_alpha, output ready);
endinterface

interface abp_rsp_if;
   import abp_pkg::*;
   logic              valid;
   logic              ready;
   logic [CHAN_W-1:0] result_red;
   logic [CHAN_W-1:0] result_green;
   logic [CHAN_W-1:0] result_blue;
   logic [CHAN_W-1:0] result_alpha;
   logic              pixel_written;
   logic              paste_done;

   modport source (output valid, result_red, result_green, result_blue, result_alpha,
                   pixel_written, paste_done, input ready);
   modport sink   (input valid, result_red, result_green, result_blue, result_alpha,
                   pixel_written, paste_done, output ready);
endinterface

interface abp_csr_if;
   import abp_pkg::*;
   logic              valid;
   logic              ready;
   logic [CSR_IW-1:0] index;
   logic [OFS_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- hdl/alpha_blend_paste.sv -----
// Top level: RGBA framebuffer with addressed access and source-over sub-image paste.
//
//   channel   role   transfer carries
//   req_ch    in     operation, address, pixel_red/green/blue/alpha
//   rsp_ch    out    result_red/green/blue/alpha, pixel_written, paste_done
//   csr_ch    in     index, data (register write, always ready)
//
// One item is in flight at a time: a write goes straight from transfer to its result,
// a read or a paste that lands inside the destination steps through address, memory read,
// blend and result, and a clipped paste or an unused code goes straight to result. The
// registered read of the frame memory sets the read-modify-write length. Reset is synchronous,
// clears control state and the paste offsets and sets the dimension registers to 64; frame
// memory contents are undefined until written. A stalled response holds the finished item in
// the output register; the next request is taken and waits at its result step until that register frees.
`default_nettype none

module alpha_blend_paste (
   input  wire       clock,
   input  wire       reset,
   abp_req_if.sink   req_ch,
   abp_rsp_if.source rsp_ch,
   abp_csr_if.sink   csr_ch
);
   import abp_pkg::*;

   // Configuration registers
   logic [DIM_W-1:0] dest_width_ff, dest_height_ff, sub_width_ff, sub_height_ff;
   logic [OFS_W-1:0] paste_x_ff, paste_y_ff;

   // Sub-image counters
   logic [COL_W-1:0] src_col_ff, src_col_in;
   logic [ROW_W-1:0] src_row_ff, src_row_in;

   // Sequencer
   state_type state_ff, state_in;

   // Item registers
   logic [1:0]          op_ff;
   logic [STORE_AW-1:0] idx_ff, idx_in;
   logic [PIX_W-1:0]    px_ff, px_in;
   logic                written_ff, written_in;
   logic                done_ff, done_in;

   // Response registers
   logic                rsp_valid_ff;
   logic [PIX_W-1:0]    rsp_px_ff;
   logic                rsp_written_ff, rsp_done_ff;

   // Frame memory
   logic [PIX_W-1:0] frame_mem [STORE_DEPTH];
   logic [PIX_W-1:0] mem_q_ff;
   logic             mem_we;

   // Paste placement
   logic signed [OFS_W:0]   col_s, row_s;
   logic                    hit;
   logic                    last_col, last_row;
   logic [2*DIM_W-1:0]      paste_idx;

   logic req_xfer, rsp_free, push;
   logic [CHAN_W-1:0] da, sa;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_xfer     = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;
   assign rsp_free     = !rsp_valid_ff || rsp_ch.ready;
   assign push         = (state_ff == ST_PUSH) && rsp_free;
   assign mem_we       = push && written_ff;

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.result_red    = rsp_px_ff[4*CHAN_W-1:3*CHAN_W];
   assign rsp_ch.result_green  = rsp_px_ff[3*CHAN_W-1:2*CHAN_W];
   assign rsp_ch.result_blue   = rsp_px_ff[2*CHAN_W-1:CHAN_W];
   assign rsp_ch.result_alpha  = rsp_px_ff[CHAN_W-1:0];
   assign rsp_ch.pixel_written = rsp_written_ff;
   assign rsp_ch.paste_done    = rsp_done_ff;

   // Place the current sub-image pixel and test it against the destination
   always_comb begin
      col_s = $signed({paste_x_ff[OFS_W-1], paste_x_ff})
            + $signed({{(OFS_W+1-COL_W){1'b0}}, src_col_ff});
      row_s = $signed({paste_y_ff[OFS_W-1], paste_y_ff})
            + $signed({{(OFS_W+1-ROW_W){1'b0}}, src_row_ff});
      hit = !col_s[OFS_W] && !row_s[OFS_W]
         && (col_s[OFS_W-1:0] < {1'b0, dest_width_ff})
         && (row_s[OFS_W-1:0] < {1'b0, dest_height_ff});
      paste_idx = row_s[DIM_W-1:0] * dest_width_ff + {{DIM_W{1'b0}}, col_s[DIM_W-1:0]};
      last_col = ({1'b0, src_col_ff} + 1'b1 >= DIM_W'(sub_width_ff))
              || (src_col_ff >= COL_W'(MAX_WIDTH - 1));
      last_row = ({1'b0, src_row_ff} + 1'b1 >= DIM_W'(sub_height_ff))
              || (src_row_ff >= ROW_W'(MAX_HEIGHT - 1));
   end

   // Next state and item registers
   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      px_in      = px_ff;
      written_in = written_ff;
      done_in    = done_ff;
      src_col_in = src_col_ff;
      src_row_in = src_row_ff;
      da = mem_q_ff[CHAN_W-1:0];
      sa = px_ff[CHAN_W-1:0];
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               px_in      = {req_ch.pixel_red, req_ch.pixel_green,
                             req_ch.pixel_blue, req_ch.pixel_alpha};
               idx_in     = req_ch.address[STORE_AW-1:0];
               written_in = 1'b0;
               done_in    = 1'b0;
               case (req_ch.operation)
                  OP_WRITE: begin
                     written_in = 1'b1;
                     state_in   = ST_PUSH;
                  end
                  OP_READ: begin
                     state_in = ST_READ;
                  end
                  OP_PASTE: begin
                     idx_in = paste_idx[STORE_AW-1:0];
                     if (hit) begin
                        state_in = ST_READ;
                     end else begin
                        px_in    = '0;
                        state_in = ST_PUSH;
                     end
                     // advance the raster counters
                     if (last_col) begin
                        src_col_in = '0;
                        if (last_row) begin
                           src_row_in = '0;
                           done_in    = 1'b1;
                        end else begin
                           src_row_in = src_row_ff + 1'b1;
                        end
                     end else begin
                        src_col_in = src_col_ff + 1'b1;
                     end
                  end
                  default: begin
                     px_in    = '0;
                     state_in = ST_PUSH;
                  end
               endcase
            end
         end
         ST_READ: begin
            state_in = ST_MIX;
         end
         ST_MIX: begin
            // pass the read pixel through for a read, else blend the source held in px_ff over it
            if (op_ff == OP_READ) begin
               px_in = mem_q_ff;
            end else if (sa == CHAN_MAX) begin
               px_in      = {px_ff[PIX_W-1:CHAN_W], CHAN_MAX};
               written_in = 1'b1;
            end else if (sa != '0) begin
               px_in = {mix_chan(px_ff[4*CHAN_W-1:3*CHAN_W],
                                 mem_q_ff[4*CHAN_W-1:3*CHAN_W], sa),
                        mix_chan(px_ff[3*CHAN_W-1:2*CHAN_W],
                                 mem_q_ff[3*CHAN_W-1:2*CHAN_W], sa),
                        mix_chan(px_ff[2*CHAN_W-1:CHAN_W],
                                 mem_q_ff[2*CHAN_W-1:CHAN_W], sa),
                        mix_alpha(da, sa)};
               written_in = 1'b1;
            end else begin
               px_in = mem_q_ff;
            end
            state_in = ST_PUSH;
         end
         ST_PUSH: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         src_col_ff     <= '0;
         src_row_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
         dest_width_ff  <= DIM_W'(MAX_WIDTH);
         dest_height_ff <= DIM_W'(MAX_HEIGHT);
         sub_width_ff   <= DIM_W'(MAX_WIDTH);
         sub_height_ff  <= DIM_W'(MAX_HEIGHT);
         paste_x_ff     <= '0;
         paste_y_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         src_col_ff <= src_col_in;
         src_row_ff <= src_row_in;
         if (push) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_ch.index)
               REG_DEST_WIDTH:  dest_width_ff  <= csr_ch.data[DIM_W-1:0];
               REG_DEST_HEIGHT: dest_height_ff <= csr_ch.data[DIM_W-1:0];
               REG_SUB_WIDTH:   sub_width_ff   <= csr_ch.data[DIM_W-1:0];
               REG_SUB_HEIGHT:  sub_height_ff  <= csr_ch.data[DIM_W-1:0];
               REG_PASTE_X:     paste_x_ff     <= csr_ch.data;
               REG_PASTE_Y:     paste_y_ff     <= csr_ch.data;
               default: ;
            endcase
         end
      end
   end

   // Item and response payload
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         op_ff <= req_ch.operation;
      end
      idx_ff     <= idx_in;
      px_ff      <= px_in;
      written_ff <= written_in;
      done_ff    <= done_in;
      if (push) begin
         rsp_px_ff      <= px_ff;
         rsp_written_ff <= written_ff;
         rsp_done_ff    <= done_ff;
      end
   end

   // Frame memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         frame_mem[idx_ff] <= px_ff;
      end
      mem_q_ff <= frame_mem[idx_ff];
   end

endmodule

`default_nettype wire

// ----- bench/tb_alpha_blend_paste.sv -----
// Self-checking bench for alpha_blend_paste: directed table, random paste phases, in-order checks.
`timescale 1ns / 1ps

module tb_alpha_blend_paste;
   import abp_pkg::*;

   localparam int CYCLE_LIMIT  = 500000;
   localparam int RANDOM_ITEMS = 600;
   localparam int PLAN_LEN     = 23;
   // Register index with no register behind it
   localparam logic [CSR_IW-1:0] REG_SPARE = 3'd7;

   typedef struct packed {
      op_type            op;
      logic [ADDR_W-1:0] addr;
      logic [CHAN_W-1:0] red, green, blue, alpha;
   } pixel_req_t;

   typedef struct packed {
      logic [CHAN_W-1:0] red, green, blue, alpha;
      logic              written;
      logic              done;
   } pixel_rsp_t;

   typedef struct packed {
      logic              is_reg;
      logic [CSR_IW-1:0] reg_sel;
      logic [OFS_W-1:0]  reg_val;
      pixel_req_t        item;
      logic              typed;
      pixel_rsp_t        want;
   } plan_row_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   abp_req_if req_ch();
   abp_rsp_if rsp_ch();
   abp_csr_if csr_ch();

   alpha_blend_paste i_dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch),
      .csr_ch(csr_ch)
   );

   always #5 clock = ~clock;

   // Shadow framebuffer, paste counters and registers
   logic [PIX_W-1:0]        frame_copy [STORE_DEPTH];
   bit                      painted [STORE_DEPTH];
   int                      painted_addrs [$];
   logic [COL_W-1:0]        src_col = '0;
   logic [ROW_W-1:0]        src_row = '0;
   logic [DIM_W-1:0]        dest_w = 7'd64;
   logic [DIM_W-1:0]        dest_h = 7'd64;
   logic [DIM_W-1:0]        sub_w  = 7'd64;
   logic [DIM_W-1:0]        sub_h  = 7'd64;
   logic signed [OFS_W-1:0] ofs_x  = '0;
   logic signed [OFS_W-1:0] ofs_y  = '0;

   pixel_rsp_t pending_pixels [$];
   pixel_rsp_t oldest_pixel;
   plan_row_t  plan [PLAN_LEN];
   int         errors = 0;
   int         cycles = 0;
   int         items_sent = 0;
   bit         steady = 1'b0;

   // Locate the framebuffer entry the next paste pixel lands on
   function automatic bit paste_target(output int idx);
      int col, row;
      col = int'(ofs_x) + int'(src_col);
      row = int'(ofs_y) + int'(src_row);
      idx = 0;
      if (col < 0 || row < 0 || col >= int'(dest_w) || row >= int'(dest_h)) return 1'b0;
      idx = (row * int'(dest_w) + col) % STORE_DEPTH;
      return 1'b1;
   endfunction

   function automatic void paint(int idx, logic [PIX_W-1:0] px);
      frame_copy[idx] = px;
      if (!painted[idx]) begin
         painted[idx] = 1'b1;
         painted_addrs.push_back(idx);
      end
   endfunction

   function automatic logic [CHAN_W-1:0] blend_chan(int s, int d, int a);
      return CHAN_W'((a * s + (256 - a) * d) >> 8);
   endfunction

   // Apply one accepted item to the shadow state and return the pixel it yields
   function automatic pixel_rsp_t composite_item(pixel_req_t it);
      pixel_rsp_t       res;
      logic [PIX_W-1:0] px, d;
      int               idx, da, sa;
      bit               last_col, last_row;
      res = '0;
      px  = '0;
      case (it.op)
         OP_WRITE: begin
            px = {it.red, it.green, it.blue, it.alpha};
            paint(int'(it.addr), px);
            res.written = 1'b1;
         end
         OP_READ: px = frame_copy[it.addr];
         OP_PASTE: begin
            last_col = (int'(src_col) + 1 >= int'(sub_w)) || (src_col >= COL_W'(MAX_WIDTH - 1));
            last_row = (int'(src_row) + 1 >= int'(sub_h)) || (src_row >= ROW_W'(MAX_HEIGHT - 1));
            if (paste_target(idx)) begin
               d  = frame_copy[idx];
               sa = int'(it.alpha);
               if (it.alpha == CHAN_MAX) begin
                  px = {it.red, it.green, it.blue, CHAN_MAX};
                  paint(idx, px);
                  res.written = 1'b1;
               end else if (it.alpha != '0) begin
                  da = int'(d[7:0]);
                  px = {blend_chan(it.red, d[31:24], sa), blend_chan(it.green, d[23:16], sa),
                        blend_chan(it.blue, d[15:8], sa),
                        CHAN_W'(255 - (((255 - da) * (255 - sa)) >> 8))};
                  paint(idx, px);
                  res.written = 1'b1;
               end else begin
                  px = d;
               end
            end
            // Advance the raster position
            if (last_col) begin
               src_col = '0;
               if (last_row) begin
                  src_row  = '0;
                  res.done = 1'b1;
               end else begin
                  src_row = src_row + 1'b1;
               end
            end else begin
               src_col = src_col + 1'b1;
            end
         end
         default: ;
      endcase
      {res.red, res.green, res.blue, res.alpha} = px;
      return res;
   endfunction

   function automatic plan_row_t typed_row(op_type op, int addr, logic [PIX_W-1:0] px,
                                           logic [PIX_W-1:0] res, logic wr, logic dn);
      plan_row_t r;
      r = '0;
      r.item.op   = op;
      r.item.addr = ADDR_W'(addr);
      {r.item.red, r.item.green, r.item.blue, r.item.alpha} = px;
      r.typed = 1'b1;
      {r.want.red, r.want.green, r.want.blue, r.want.alpha} = res;
      r.want.written = wr;
      r.want.done    = dn;
      return r;
   endfunction

   function automatic plan_row_t item_row(op_type op, int addr, logic [PIX_W-1:0] px);
      plan_row_t r;
      r = typed_row(op, addr, px, '0, 1'b0, 1'b0);
      r.typed = 1'b0;
      return r;
   endfunction

   function automatic plan_row_t reg_row(logic [CSR_IW-1:0] sel, logic [OFS_W-1:0] val);
      plan_row_t r;
      r = '0;
      r.is_reg  = 1'b1;
      r.reg_sel = sel;
      r.reg_val = val;
      return r;
   endfunction

   function automatic logic [CHAN_W-1:0] rand_chan();
      if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? CHAN_MAX : '0;
      return CHAN_W'($urandom_range(0, 255));
   endfunction

   function automatic pixel_req_t rand_pixel(op_type op, int addr);
      pixel_req_t it;
      it.op    = op;
      it.addr  = ADDR_W'(addr);
      it.red   = rand_chan();
      it.green = rand_chan();
      it.blue  = rand_chan();
      it.alpha = rand_chan();
      return it;
   endfunction

   function automatic logic [OFS_W-1:0] draw_dim(bit wide);
      case ($urandom_range(0, 9))
         0: return 8'd0;
         1: return 8'd127;
         2: return 8'd64;
         3: return 8'd1;
         default: return wide ? OFS_W'($urandom_range(1, 16)) : OFS_W'($urandom_range(1, 6));
      endcase
   endfunction

   function automatic logic [OFS_W-1:0] draw_ofs();
      case ($urandom_range(0, 5))
         0: return OFS_W'($urandom_range(0, 255));
         1: return 8'h80;
         2: return 8'h7F;
         default: return OFS_W'($urandom_range(0, 10) - 5);
      endcase
   endfunction

   // Drive one item and hold it until the block takes it
   task automatic send_item(pixel_req_t it, bit typed, pixel_rsp_t want);
      int         gap;
      pixel_rsp_t res;
      gap = steady ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.operation   <= it.op;
      req_ch.address     <= it.addr;
      req_ch.pixel_red   <= it.red;
      req_ch.pixel_green <= it.green;
      req_ch.pixel_blue  <= it.blue;
      req_ch.pixel_alpha <= it.alpha;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      res = composite_item(it);
      pending_pixels.push_back(typed ? want : res);
      if (it.op != OP_UNUSED) items_sent++;
   endtask

   // Hold the sender off until every result is back, then let the pipe settle
   task automatic drain();
      req_ch.valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IW-1:0] sel, logic [OFS_W-1:0] val);
      @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= sel;
      csr_ch.data  <= val;
      do @(posedge clock); while (csr_ch.ready !== 1'b1);
      csr_ch.valid <= 1'b0;
      case (sel)
         REG_DEST_WIDTH:  dest_w = val[DIM_W-1:0];
         REG_DEST_HEIGHT: dest_h = val[DIM_W-1:0];
         REG_SUB_WIDTH:   sub_w  = val[DIM_W-1:0];
         REG_SUB_HEIGHT:  sub_h  = val[DIM_W-1:0];
         REG_PASTE_X:     ofs_x  = val;
         REG_PASTE_Y:     ofs_y  = val;
         default: ;
      endcase
   endtask

   // Paint the landing entry first if it was never written, then paste
   task automatic send_paste();
      pixel_req_t it;
      int         idx;
      if (paste_target(idx) && !painted[idx]) send_item(rand_pixel(OP_WRITE, idx), 1'b0, '0);
      it = rand_pixel(OP_PASTE, $urandom_range(0, STORE_DEPTH - 1));
      case ($urandom_range(0, 5))
         0: it.alpha = '0;
         1: it.alpha = CHAN_MAX;
         2: it.alpha = 8'd1;
         3: it.alpha = 8'hFE;
         default: ;
      endcase
      send_item(it, 1'b0, '0);
   endtask

   task automatic run_phase(logic [OFS_W-1:0] dw, logic [OFS_W-1:0] dh, logic [OFS_W-1:0] sw,
                            logic [OFS_W-1:0] sh, logic [OFS_W-1:0] px, logic [OFS_W-1:0] py,
                            int count, bit paste_only, bit hold_mid);
      int pick;
      drain();
      write_reg(REG_DEST_WIDTH, dw);
      write_reg(REG_DEST_HEIGHT, dh);
      write_reg(REG_SUB_WIDTH, sw);
      write_reg(REG_SUB_HEIGHT, sh);
      write_reg(REG_PASTE_X, px);
      write_reg(REG_PASTE_Y, py);
      steady = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < count; n++) begin
         if (hold_mid && n == count / 2) drain();
         pick = paste_only ? 0 : $urandom_range(0, 99);
         if (pick < 70) begin
            send_paste();
         end else if (pick < 82 || painted_addrs.size() == 0) begin
            send_item(rand_pixel(OP_WRITE, $urandom_range(0, STORE_DEPTH - 1)), 1'b0, '0);
         end else if (pick < 95) begin
            send_item(rand_pixel(OP_READ,
                                 painted_addrs[$urandom_range(0, painted_addrs.size() - 1)]),
                      1'b0, '0);
         end else begin
            send_item(rand_pixel(OP_UNUSED, $urandom_range(0, STORE_DEPTH - 1)), 1'b0, '0);
         end
      end
   endtask

   task automatic check_field(string name, logic [CHAN_W-1:0] want, logic [CHAN_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         errors++;
      end
   endtask

   // Compare every response transfer with the oldest pending pixel
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (pending_pixels.size() == 0) begin
            $error("response transfer with nothing pending");
            errors++;
         end else begin
            oldest_pixel = pending_pixels.pop_front();
            check_field("result_red", oldest_pixel.red, rsp_ch.result_red);
            check_field("result_green", oldest_pixel.green, rsp_ch.result_green);
            check_field("result_blue", oldest_pixel.blue, rsp_ch.result_blue);
            check_field("result_alpha", oldest_pixel.alpha, rsp_ch.result_alpha);
            check_field("pixel_written", CHAN_W'(oldest_pixel.written),
                        CHAN_W'(rsp_ch.pixel_written));
            check_field("paste_done", CHAN_W'(oldest_pixel.done), CHAN_W'(rsp_ch.paste_done));
         end
      end
   end

   // Hold the response side off at random before each result, except in steady phases
   initial begin
      int stall;
      rsp_ch.ready <= 1'b0;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         stall = steady ? 0 : $urandom_range(0, 5);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (rsp_ch.valid !== 1'b1);
      end
   end

   // Abort a hung run
   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("[alpha_blend_paste] ERROR");
      $finish;
   end

   initial begin
      req_ch.valid       <= 1'b0;
      req_ch.operation   <= OP_WRITE;
      req_ch.address     <= '0;
      req_ch.pixel_red   <= '0;
      req_ch.pixel_green <= '0;
      req_ch.pixel_blue  <= '0;
      req_ch.pixel_alpha <= '0;
      csr_ch.valid       <= 1'b0;
      csr_ch.index       <= '0;
      csr_ch.data        <= '0;

      // Directed rows: extremes, every code, blend corners, clipping, tiny sub-image
      plan = '{
         typed_row(OP_WRITE, 0, 32'h12345678, 32'h12345678, 1'b1, 1'b0),
         typed_row(OP_READ, 0, 32'h0, 32'h12345678, 1'b0, 1'b0),
         typed_row(OP_WRITE, 4095, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 1'b0),
         typed_row(OP_READ, 4095, 32'h0, 32'hFFFFFFFF, 1'b0, 1'b0),
         typed_row(OP_WRITE, 1, 32'h0, 32'h0, 1'b1, 1'b0),
         typed_row(OP_WRITE, 2, 32'h807F01FE, 32'h807F01FE, 1'b1, 1'b0),
         typed_row(OP_WRITE, 3, 32'hFF00FF00, 32'hFF00FF00, 1'b1, 1'b0),
         typed_row(OP_WRITE, 4, 32'h00FF00FF, 32'h00FF00FF, 1'b1, 1'b0),
         typed_row(OP_UNUSED, 4095, 32'hFFFFFFFF, 32'h0, 1'b0, 1'b0),
         typed_row(OP_PASTE, 0, 32'hA55AC3FF, 32'hA55AC3FF, 1'b1, 1'b0),
         typed_row(OP_PASTE, 0, 32'hFFFFFF00, 32'h0, 1'b0, 1'b0),
         item_row(OP_PASTE, 0, 32'h00FF7F80),
         item_row(OP_PASTE, 0, 32'h00FF0001),
         item_row(OP_PASTE, 0, 32'hFF00FFFE),
         item_row(OP_READ, 2, 32'h0),
         reg_row(REG_PASTE_X, 8'h80),
         typed_row(OP_PASTE, 0, 32'h123456FF, 32'h0, 1'b0, 1'b0),
         reg_row(REG_PASTE_X, 8'h7F),
         reg_row(REG_SUB_WIDTH, 8'h00),
         reg_row(REG_SUB_HEIGHT, 8'h00),
         typed_row(OP_PASTE, 0, 32'h123456FF, 32'h0, 1'b0, 1'b1),
         reg_row(REG_SPARE, 8'hFF),
         typed_row(OP_PASTE, 0, 32'h654321FF, 32'h0, 1'b0, 1'b1)
      };

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].is_reg) begin
            drain();
            write_reg(plan[i].reg_sel, plan[i].reg_val);
         end else begin
            send_item(plan[i].item, plan[i].typed, plan[i].want);
         end
      end

      // Run the counters to their ceilings along a row and down a column
      run_phase(8'd64, 8'd64, 8'd127, 8'd1, 8'd0, 8'd0, 70, 1'b1, 1'b1);
      run_phase(8'd64, 8'd64, 8'd1, 8'd127, 8'd0, 8'd0, 70, 1'b1, 1'b0);

      while (items_sent < RANDOM_ITEMS + PLAN_LEN) begin
         run_phase(draw_dim(1'b1), draw_dim(1'b1), draw_dim(1'b0), draw_dim(1'b0),
                   draw_ofs(), draw_ofs(), $urandom_range(20, 60), 1'b0,
                   ($urandom_range(0, 2) == 0));
      end

      drain();
      repeat (10) @(posedge clock);
      if (errors == 0) begin
         $display("[alpha_blend_paste] OK");
      end else begin
         $display("[alpha_blend_paste] ERROR");
      end
      $finish;
   end

endmodule

// ----- files.f -----
hdl/abp_pkg.sv
hdl/abp_if.sv
hdl/alpha_blend_paste.sv
bench/tb_alpha_blend_paste.sv
